// ===== rtl/core/lse_pkg.sv =====
package lse_pkg;

  localparam int CNT_W  = 6;
  localparam int STEP_W = 11;
  localparam int WORK_W = 13;
  localparam int PADDR_W = 3;

  localparam int LSE_MAX_PIXELS       = 60;
  localparam int LSE_OFF_FRAME_LENGTH = 60;
  localparam int LSE_RAINBOW_STEPS    = 1380;
  localparam int LSE_FADE_TOP         = 250;

  localparam logic [CNT_W-1:0] PIXEL_COUNT_RESET = 6'd20;
  localparam logic REG_PIXEL_COUNT = 1'b0;

  localparam logic CMD_NEW  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] EFF_STATIC  = 8'd1;
  localparam logic [7:0] EFF_FLASH   = 8'd2;
  localparam logic [7:0] EFF_RAINBOW = 8'd3;
  localparam logic [7:0] EFF_FADE    = 8'd4;
  localparam logic [7:0] EFF_SCAN    = 8'd5;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_FLASH   = 3'd2;
  localparam logic [2:0] ACT_RAINBOW = 3'd3;
  localparam logic [2:0] ACT_FADE    = 3'd4;
  localparam logic [2:0] ACT_SCAN    = 3'd5;

  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic signed [WORK_W-1:0] RB_START = 13'sd2550;
  localparam logic signed [WORK_W-1:0] RB_DELTA = 13'sd3;
  localparam logic signed [WORK_W-1:0] CHAN_MAX = 13'sd255;
  localparam logic signed [WORK_W-1:0] TENTHS_MAX = 13'sd2550;
  localparam logic [12:0] RECIP_10 = 13'd6554;

  typedef struct packed {
    logic       cmd;
    logic [7:0] level;
    logic [7:0] effect;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lse_in_t;

  typedef struct packed {
    logic [23:0] pixel_word;
    logic        frame_end;
  } lse_out_t;

  typedef struct packed {
    logic       latch;
    logic       update;
    logic       conv;
    logic [1:0] conv_ch;
    logic       load;
  } lse_cmd_t;

  typedef struct packed {
    logic rainbow;
    logic has_frame;
    logic out_free;
    logic last;
  } lse_sts_t;

endpackage

// ===== rtl/core/lse_ctrl.sv =====
module lse_ctrl import lse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  lse_sts_t sts,
  output lse_cmd_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_CONV   = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [1:0] conv_ch, conv_ch_next;

  always_comb begin
    state_next   = state;
    conv_ch_next = conv_ch;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        conv_ch_next = CH_RED;
        if (sts.rainbow) state_next = S_CONV;
        else if (sts.has_frame) state_next = S_EMIT;
        else state_next = S_IDLE;
      end
      S_CONV: begin
        conv_ch_next = conv_ch + 2'd1;
        if (conv_ch == CH_BLUE) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free && sts.last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      conv_ch <= CH_RED;
    end else begin
      state   <= state_next;
      conv_ch <= conv_ch_next;
    end
  end

  assign req_stall   = (state != S_IDLE);
  assign ctl.latch   = (state == S_IDLE) && req_valid;
  assign ctl.update  = (state == S_UPDATE);
  assign ctl.conv    = (state == S_CONV);
  assign ctl.conv_ch = conv_ch;
  assign ctl.load    = (state == S_EMIT) && sts.out_free;

endmodule

// ===== rtl/core/lse_datapath.sv =====
module lse_datapath import lse_pkg::*; #(
  parameter int MAX_PIXELS       = LSE_MAX_PIXELS,
  parameter int OFF_FRAME_LENGTH = LSE_OFF_FRAME_LENGTH,
  parameter int RAINBOW_STEPS    = LSE_RAINBOW_STEPS,
  parameter int FADE_TOP         = LSE_FADE_TOP
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] pixel_count,
  input  lse_in_t          req,
  input  lse_cmd_t         ctl,
  output lse_sts_t         sts,
  output logic             pix_valid,
  input  logic             pix_stall,
  output lse_out_t         pix
);

  localparam logic [CNT_W-1:0]  MAX_PIX  = CNT_W'(MAX_PIXELS);
  localparam logic [CNT_W-1:0]  OFF_LEN  = CNT_W'(OFF_FRAME_LENGTH);
  localparam logic [STEP_W-1:0] RB_STEPS = STEP_W'(RAINBOW_STEPS);
  localparam logic [STEP_W-1:0] FADE_END = STEP_W'(FADE_TOP);

  function automatic logic [23:0] pack(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    return {g, r, b};
  endfunction

  function automatic logic [7:0] tenths_byte(input logic signed [WORK_W-1:0] t);
    logic [11:0] u;
    logic [24:0] prod;
    if (t < 0) u = '0;
    else if (t > TENTHS_MAX) u = 12'(TENTHS_MAX);
    else u = t[11:0];
    prod = 25'(u) * 25'(RECIP_10);
    return prod[23:16];
  endfunction

  lse_in_t                    item;
  logic [2:0]                 active, active_next;
  logic [23:0]                base, base_next;
  logic signed [WORK_W-1:0]   work [3];
  logic signed [WORK_W-1:0]   work_next [3];
  logic                       going_up, going_up_next;
  logic [STEP_W-1:0]          step, step_next;
  logic [1:0]                 phase, phase_next;
  logic                       flash_on, flash_on_next;

  logic [CNT_W-1:0]           frame_len, frame_len_next;
  logic [23:0]                frame_colour, frame_colour_next, conv_colour;
  logic                       lit_all, lit_all_next;
  logic                       lit_en, lit_en_next;
  logic [CNT_W-1:0]           lit_idx, lit_idx_next;
  logic [CNT_W-1:0]           emit_idx;

  logic [CNT_W-1:0]           fsize;
  logic [STEP_W-1:0]          scan_s;
  logic [CNT_W-1:0]           scan_p;
  logic                       scan_up;
  logic [STEP_W-1:0]          rb_step, fd_step;
  logic signed [WORK_W-1:0]   rb_d;
  logic [7:0]                 conv_byte;
  logic                       lit;

  assign fsize = (pixel_count == '0) ? CNT_W'(1) :
                 (pixel_count > MAX_PIX) ? MAX_PIX : pixel_count;

  assign scan_s  = (step > STEP_W'(fsize)) ? STEP_W'(fsize) : step;
  assign scan_p  = scan_s[CNT_W-1:0];
  assign rb_step = step + STEP_W'(1);
  assign fd_step = going_up ? step + STEP_W'(1) : step - STEP_W'(1);
  assign rb_d    = going_up ? RB_DELTA : -RB_DELTA;

  always_comb begin
    active_next       = active;
    base_next         = base;
    work_next         = work;
    going_up_next     = going_up;
    step_next         = step;
    phase_next        = phase;
    flash_on_next     = flash_on;
    frame_len_next    = '0;
    frame_colour_next = '0;
    lit_all_next      = 1'b1;
    lit_en_next       = 1'b0;
    lit_idx_next      = '0;
    scan_up           = going_up;
    if (item.cmd == CMD_NEW) begin
      going_up_next = 1'b1;
      step_next     = '0;
      phase_next    = PH_1;
      flash_on_next = 1'b1;
      base_next     = pack(item.red, item.green, item.blue);
      work_next[0]  = WORK_W'(item.red);
      work_next[1]  = WORK_W'(item.green);
      work_next[2]  = WORK_W'(item.blue);
      active_next   = ACT_NONE;
      if (item.level == '0) begin
        frame_len_next = (item.effect == EFF_SCAN) ? OFF_LEN : fsize;
      end else begin
        case (item.effect)
          EFF_STATIC: begin
            frame_len_next    = fsize;
            frame_colour_next = pack(item.red, item.green, item.blue);
          end
          EFF_FLASH: active_next = ACT_FLASH;
          EFF_FADE: active_next = ACT_FADE;
          EFF_RAINBOW: begin
            active_next  = ACT_RAINBOW;
            work_next[0] = RB_START;
            work_next[1] = RB_START;
            work_next[2] = RB_START;
          end
          EFF_SCAN: begin
            active_next    = ACT_SCAN;
            frame_len_next = OFF_LEN;
          end
          default: ;
        endcase
      end
    end else begin
      case (active)
        ACT_FLASH: begin
          frame_len_next    = fsize;
          frame_colour_next = flash_on ? base : '0;
          flash_on_next     = !flash_on;
        end
        ACT_RAINBOW: begin
          frame_len_next = fsize;
          step_next      = rb_step;
          case (phase)
            PH_1: work_next[0] = work[0] - rb_d;
            PH_2: begin
              work_next[0] = work[0] + rb_d;
              work_next[1] = work[1] - rb_d;
            end
            PH_3: begin
              work_next[1] = work[1] + rb_d;
              work_next[2] = work[2] - rb_d;
            end
            default: ;
          endcase
          if (rb_step >= RB_STEPS) begin
            step_next = '0;
            if (phase == PH_3 && going_up) going_up_next = 1'b0;
            else if (phase == PH_1 && !going_up) going_up_next = 1'b1;
            else if (going_up) phase_next = phase + 2'd1;
            else phase_next = phase - 2'd1;
          end
        end
        ACT_FADE: begin
          step_next = fd_step;
          for (int c = 0; c < 3; c++) begin
            if (work[2'(c)] != '0) begin
              if (going_up) work_next[2'(c)] = work[2'(c)] - 13'sd1;
              else if (work[2'(c)] < CHAN_MAX) work_next[2'(c)] = work[2'(c)] + 13'sd1;
            end
          end
          frame_len_next    = fsize;
          frame_colour_next = pack(work_next[0][7:0], work_next[1][7:0],
                                   work_next[2][7:0]);
          if (fd_step == FADE_END) going_up_next = 1'b0;
          else if (fd_step == STEP_W'(1)) going_up_next = 1'b1;
        end
        ACT_SCAN: begin
          frame_colour_next = base;
          lit_all_next      = 1'b0;
          if (going_up) begin
            frame_len_next = scan_p + CNT_W'(1);
            lit_en_next    = 1'b1;
            lit_idx_next   = scan_p;
          end else begin
            frame_len_next = scan_p + CNT_W'(2);
            lit_en_next    = (scan_p != '0);
            lit_idx_next   = scan_p - CNT_W'(1);
          end
          if (scan_p == fsize) scan_up = 1'b0;
          else if (scan_p == '0 && !going_up) scan_up = 1'b1;
          going_up_next = scan_up;
          if (scan_up) step_next = scan_s + STEP_W'(1);
          else if (scan_s != '0) step_next = scan_s - STEP_W'(1);
          else step_next = scan_s;
        end
        default: frame_len_next = '0;
      endcase
    end
  end

  always_comb begin
    conv_colour = frame_colour;
    case (ctl.conv_ch)
      CH_RED: begin
        conv_byte         = tenths_byte(work[0]);
        conv_colour[15:8] = conv_byte;
      end
      CH_GREEN: begin
        conv_byte          = tenths_byte(work[1]);
        conv_colour[23:16] = conv_byte;
      end
      default: begin
        conv_byte        = tenths_byte(work[2]);
        conv_colour[7:0] = conv_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) item <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= ACT_NONE;
      base     <= '0;
      work[0]  <= '0;
      work[1]  <= '0;
      work[2]  <= '0;
      going_up <= 1'b1;
      step     <= '0;
      phase    <= PH_1;
      flash_on <= 1'b1;
    end else if (ctl.update) begin
      active   <= active_next;
      base     <= base_next;
      work     <= work_next;
      going_up <= going_up_next;
      step     <= step_next;
      phase    <= phase_next;
      flash_on <= flash_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update) begin
      frame_len    <= frame_len_next;
      frame_colour <= frame_colour_next;
      lit_all      <= lit_all_next;
      lit_en       <= lit_en_next;
      lit_idx      <= lit_idx_next;
      emit_idx     <= '0;
    end else begin
      if (ctl.conv) frame_colour <= conv_colour;
      if (ctl.load) emit_idx <= emit_idx + CNT_W'(1);
    end
  end

  assign lit = lit_all || (lit_en && emit_idx == lit_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (ctl.load) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pix.pixel_word <= lit ? frame_colour : '0;
      pix.frame_end  <= sts.last;
    end
  end

  assign sts.rainbow   = (item.cmd == CMD_TICK) && (active == ACT_RAINBOW);
  assign sts.has_frame = (frame_len_next != '0);
  assign sts.out_free  = !pix_valid || !pix_stall;
  assign sts.last      = (emit_idx == frame_len - CNT_W'(1));

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (!pix_valid || !pix_stall))
    else $error("item loaded over an untaken item");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (emit_idx < frame_len))
    else $error("word index past frame length");

  a_fade_bound: assert property (@(posedge clk) disable iff (rst)
    (active == ACT_FADE) |-> (step <= FADE_END))
    else $error("fade step past top");

  a_rainbow_bound: assert property (@(posedge clk) disable iff (rst)
    (active == ACT_RAINBOW) |-> (step < RB_STEPS))
    else $error("rainbow step not wrapped");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (active == ACT_SCAN) |-> (step <= STEP_W'(MAX_PIX)))
    else $error("scan position past strip");

endmodule

// ===== rtl/core/led_strip_effect_engine.sv =====
// led strip effect engine
// req channel (req_valid/req_stall/req): one item is either a new command
// (cmd 0: level, effect, colour) or an animation tick (cmd 1)
// pix channel (pix_valid/pix_stall/pix): packed grb pixel words, frame_end
// set on the last word of each frame
// apb port: register 0 at byte address 0 holds pixel_count (reset 20)
// timing: an item is taken in the idle cycle, the next cycle updates the
// effect state; a rainbow tick then converts tenths to bytes, one channel
// per cycle through a constant multiplier
// words then leave one per cycle from the output register while pix is not
// stalled; an item with no words goes back to idle after the update
// the first word is loaded in the emit state after the update (after conversion for rainbow)
// req_stall is high while an item is being worked on
// a stalled pix holds its word and the frame walk pauses; the next req item
// is taken while the last word of a frame still waits
// reset (rst, synchronous) clears the effect to none, pixel_count to 20
module led_strip_effect_engine import lse_pkg::*; #(
  parameter int MAX_PIXELS       = LSE_MAX_PIXELS,
  parameter int OFF_FRAME_LENGTH = LSE_OFF_FRAME_LENGTH,
  parameter int RAINBOW_STEPS    = LSE_RAINBOW_STEPS,
  parameter int FADE_TOP         = LSE_FADE_TOP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  lse_in_t            req,
  output logic               pix_valid,
  input  logic               pix_stall,
  output lse_out_t           pix,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CNT_W-1:0] pixel_count;
  lse_cmd_t         ctl;
  lse_sts_t         sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= PIXEL_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_COUNT) begin
      pixel_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PIXEL_COUNT) ? 32'(pixel_count) : '0;

  lse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  lse_datapath #(
    .MAX_PIXELS       (MAX_PIXELS),
    .OFF_FRAME_LENGTH (OFF_FRAME_LENGTH),
    .RAINBOW_STEPS    (RAINBOW_STEPS),
    .FADE_TOP         (FADE_TOP)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .pixel_count (pixel_count),
    .req         (req),
    .ctl         (ctl),
    .sts         (sts),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pix         (pix)
  );

endmodule

// ===== tb/lse_frame_checker.sv =====
module lse_frame_checker import lse_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  lse_in_t            req,
  input  logic               pix_valid,
  input  logic               pix_stall,
  input  lse_out_t           pix,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 pending,
  output int                 errors,
  output int                 words_checked
);

  localparam logic [PADDR_W-1:0] STRIP_LEN_ADDR = {REG_PIXEL_COUNT, 2'b00};

  logic [CNT_W-1:0]         strip_len;
  logic [2:0]               effect_now;
  logic [23:0]              base_grb;
  logic signed [WORK_W-1:0] chan [3];
  logic                     rising;
  logic [STEP_W-1:0]        step;
  logic [1:0]               phase;
  logic                     flash_lit;

  lse_out_t expected_words [$];
  int pending_n = 0;
  int mismatches = 0;
  int words_n = 0;

  assign pending       = pending_n;
  assign errors        = mismatches;
  assign words_checked = words_n;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("mismatch at word %0d: %s got %0h want %0h", words_n, what, got, want);
    end
    mismatches++;
  endtask

  function automatic int frame_len();
    if (strip_len == 0) return 1;
    if (strip_len > LSE_MAX_PIXELS) return LSE_MAX_PIXELS;
    return int'(strip_len);
  endfunction

  function automatic logic [23:0] grb(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return {g, r, b};
  endfunction

  function automatic logic [7:0] tenths_to_byte(input logic signed [WORK_W-1:0] t);
    int v;
    v = int'(t);
    if (v < 0) v = 0;
    if (v > TENTHS_MAX) v = int'(TENTHS_MAX);
    return 8'(v / 10);
  endfunction

  task automatic push_word(input logic [23:0] w, input logic last);
    lse_out_t e;
    e.pixel_word = w;
    e.frame_end  = last;
    expected_words.push_back(e);
  endtask

  task automatic push_frame(input int n, input logic [23:0] w);
    int k;
    for (k = 0; k < n; k++) push_word(w, k == n - 1);
  endtask

  task automatic predict_frames(input lse_in_t it);
    logic signed [WORK_W-1:0] d;
    int n;
    int p;
    int cnt;
    int k;
    int c;
    logic [23:0] w;
    if (it.cmd == CMD_NEW) begin
      rising     = 1'b1;
      step       = '0;
      phase      = PH_1;
      flash_lit  = 1'b1;
      base_grb   = grb(it.red, it.green, it.blue);
      chan[CH_RED]   = {5'd0, it.red};
      chan[CH_GREEN] = {5'd0, it.green};
      chan[CH_BLUE]  = {5'd0, it.blue};
      effect_now = ACT_NONE;
      if (it.level == 8'd0) begin
        if (it.effect == EFF_SCAN) push_frame(LSE_OFF_FRAME_LENGTH, 24'd0);
        else push_frame(frame_len(), 24'd0);
      end else begin
        case (it.effect)
          EFF_STATIC: push_frame(frame_len(), base_grb);
          EFF_FLASH:  effect_now = ACT_FLASH;
          EFF_FADE:   effect_now = ACT_FADE;
          EFF_RAINBOW: begin
            effect_now = ACT_RAINBOW;
            chan[CH_RED]   = RB_START;
            chan[CH_GREEN] = RB_START;
            chan[CH_BLUE]  = RB_START;
          end
          EFF_SCAN: begin
            effect_now = ACT_SCAN;
            push_frame(LSE_OFF_FRAME_LENGTH, 24'd0);
          end
          default: ;
        endcase
      end
    end else begin
      case (effect_now)
        ACT_FLASH: begin
          w = flash_lit ? base_grb : 24'd0;
          flash_lit = ~flash_lit;
          push_frame(frame_len(), w);
        end
        ACT_RAINBOW: begin
          d = rising ? RB_DELTA : -RB_DELTA;
          step = step + STEP_W'(1);
          case (phase)
            PH_1: chan[CH_RED] = chan[CH_RED] - d;
            PH_2: begin
              chan[CH_RED]   = chan[CH_RED] + d;
              chan[CH_GREEN] = chan[CH_GREEN] - d;
            end
            PH_3: begin
              chan[CH_GREEN] = chan[CH_GREEN] + d;
              chan[CH_BLUE]  = chan[CH_BLUE] - d;
            end
            default: ;
          endcase
          push_frame(frame_len(), grb(tenths_to_byte(chan[CH_RED]),
                                      tenths_to_byte(chan[CH_GREEN]),
                                      tenths_to_byte(chan[CH_BLUE])));
          if (step >= LSE_RAINBOW_STEPS) begin
            if (phase == PH_3 && rising) rising = 1'b0;
            else if (phase == PH_1 && !rising) rising = 1'b1;
            else if (rising) phase = phase + 2'd1;
            else phase = phase - 2'd1;
            step = '0;
          end
        end
        ACT_FADE: begin
          step = rising ? step + STEP_W'(1) : step - STEP_W'(1);
          for (c = 0; c < 3; c++) begin
            if (chan[2'(c)] != 0) begin
              if (rising) chan[2'(c)] = chan[2'(c)] - 13'sd1;
              else if (chan[2'(c)] < CHAN_MAX) chan[2'(c)] = chan[2'(c)] + 13'sd1;
            end
          end
          push_frame(frame_len(), grb(chan[CH_RED][7:0], chan[CH_GREEN][7:0],
                                      chan[CH_BLUE][7:0]));
          if (step == LSE_FADE_TOP) rising = 1'b0;
          else if (step == 1) rising = 1'b1;
        end
        ACT_SCAN: begin
          n = frame_len();
          if (step > n) step = STEP_W'(n);
          p = int'(step);
          if (rising) begin
            cnt = p + 1;
            for (k = 0; k < cnt; k++) push_word((k == cnt - 1) ? base_grb : 24'd0, k == cnt - 1);
          end else begin
            cnt = p + 2;
            for (k = 0; k < cnt; k++) push_word((k == p - 1) ? base_grb : 24'd0, k == cnt - 1);
          end
          if (p == n) rising = 1'b0;
          else if (p == 0 && !rising) rising = 1'b1;
          if (rising) step = step + STEP_W'(1);
          else if (step > 0) step = step - STEP_W'(1);
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    lse_out_t want;
    if (rst) begin
      strip_len  = PIXEL_COUNT_RESET;
      effect_now = ACT_NONE;
      base_grb   = '0;
      chan[CH_RED]   = '0;
      chan[CH_GREEN] = '0;
      chan[CH_BLUE]  = '0;
      rising     = 1'b1;
      step       = '0;
      phase      = PH_1;
      flash_lit  = 1'b1;
      expected_words.delete();
    end else begin
      if (psel && penable && pready && paddr == STRIP_LEN_ADDR) begin
        if (pwrite) strip_len = pwdata[CNT_W-1:0];
        else if (prdata[CNT_W-1:0] !== strip_len) begin
          report_mismatch("pixel_count readback", prdata, 32'(strip_len));
        end
      end
      if (pix_valid && !pix_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("pixel word with none expected", 32'(pix.pixel_word), 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (pix.pixel_word !== want.pixel_word) begin
            report_mismatch("pixel_word", 32'(pix.pixel_word), 32'(want.pixel_word));
          end
          if (pix.frame_end !== want.frame_end) begin
            report_mismatch("frame_end", 32'(pix.frame_end), 32'(want.frame_end));
          end
          words_n++;
        end
      end
      if (req_valid && !req_stall) predict_frames(req);
    end
    pending_n = expected_words.size();
  end

endmodule

// ===== tb/tb_led_strip_effect_engine.sv =====
module tb_led_strip_effect_engine;
  import lse_pkg::*;

  localparam logic [7:0] EFF_UNUSED_LOW  = 8'h00;
  localparam logic [7:0] EFF_UNUSED_HIGH = 8'hff;
  localparam int         IN_W            = $bits(lse_in_t);

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  lse_in_t            req;
  logic               pix_valid;
  logic               pix_stall;
  lse_out_t           pix;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int pending;
  int mismatches;
  int words_checked;
  int gap_pct;
  int stall_pct;
  int items_sent;
  int settings_used;

  led_strip_effect_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  lse_frame_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .pix           (pix),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pending       (pending),
    .errors        (mismatches),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd40_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    pix_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_item(input lse_in_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic new_cmd(input logic [7:0] lvl, input logic [7:0] eff, input logic [7:0] r,
                         input logic [7:0] g, input logic [7:0] b);
    lse_in_t it;
    it.cmd    = CMD_NEW;
    it.level  = lvl;
    it.effect = eff;
    it.red    = r;
    it.green  = g;
    it.blue   = b;
    send_item(it);
  endtask

  // tick payload bits are don't-care, so fill them at random
  task automatic tick();
    lse_in_t it;
    it = IN_W'({$urandom, $urandom});
    it.cmd = CMD_TICK;
    send_item(it);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_strip_len(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PIXEL_COUNT, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly command-then-ticks runs, some stray commands and ticks
  task automatic run_effects(input int quota, input int len);
    int counted;
    int ticks;
    logic [7:0] eff;
    logic [7:0] lvl;
    lse_in_t junk;
    counted = 0;
    while (counted < quota) begin
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 1) == 0) begin
          tick();
        end else begin
          junk = IN_W'({$urandom, $urandom});
          junk.cmd = CMD_NEW;
          send_item(junk);
        end
      end else begin
        eff = 8'($urandom_range(EFF_STATIC, EFF_SCAN));
        if ($urandom_range(0, 9) == 0) lvl = 8'h00;
        else if ($urandom_range(0, 4) == 0) lvl = 8'hff;
        else lvl = 8'($urandom_range(1, 255));
        new_cmd(lvl, eff, pick_byte(), pick_byte(), pick_byte());
        counted++;
        if (lvl == 8'h00 || eff == EFF_STATIC) ticks = $urandom_range(0, 2);
        else if (eff == EFF_SCAN && len <= 12) ticks = $urandom_range(1, 2 * len + 4);
        else if (eff == EFF_SCAN && $urandom_range(0, 3) == 0) ticks = 2 * len + 3;
        else if (eff == EFF_SCAN) ticks = $urandom_range(1, 24);
        else ticks = $urandom_range(1, 12);
        repeat (ticks) begin
          tick();
          if (lvl != 8'h00 && eff != EFF_STATIC) counted++;
        end
        if ($urandom_range(0, 24) == 0) settle();
      end
    end
  endtask

  initial begin : stimulus
    int seg;
    int v;
    int len;
    logic [31:0] val;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    gap_pct   = 11;
    stall_pct = 53;
    items_sent    = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // blanking at the reset strip length, scan blanking over the off-frame length
    new_cmd(8'h00, EFF_SCAN, 8'hff, 8'hff, 8'hff);
    new_cmd(8'h00, EFF_STATIC, 8'hff, 8'hff, 8'hff);
    settle();
    program_strip_len(32'd6);
    new_cmd(8'hff, EFF_STATIC, 8'hff, 8'h00, 8'h80);
    tick();
    new_cmd(8'h01, EFF_UNUSED_LOW, 8'h5a, 8'ha5, 8'h3c);
    new_cmd(8'h80, EFF_UNUSED_HIGH, 8'h00, 8'h00, 8'h00);
    tick();
    new_cmd(8'hff, EFF_FLASH, 8'h12, 8'h34, 8'h56);
    tick();
    tick();
    new_cmd(8'h7f, EFF_RAINBOW, 8'h00, 8'h00, 8'h00);
    tick();
    new_cmd(8'hc3, EFF_FADE, 8'h00, 8'hff, 8'h01);
    tick();
    tick();
    new_cmd(8'h01, EFF_SCAN, 8'haa, 8'h55, 8'hff);
    repeat (5) tick();
    // shrink the strip under a running scan
    settle();
    program_strip_len(32'd3);
    repeat (3) tick();

    for (seg = 0; seg < 6; seg++) begin
      settle();
      gap_pct   = (seg < 2) ? 11 : (seg < 4) ? 53 : 0;
      stall_pct = (seg < 2) ? 53 : (seg < 4) ? 11 : 0;
      case (seg)
        0: v = 1;
        1: v = 60;
        2: v = 63;
        3: v = 0;
        default: v = $urandom_range(2, 59);
      endcase
      val = ($urandom_range(0, 1) ? ($urandom & ~32'h3f) : 32'd0) | v;
      len = (v == 0) ? 1 : (v > LSE_MAX_PIXELS) ? LSE_MAX_PIXELS : v;
      program_strip_len(val);
      run_effects(50, len);
    end

    settle();
    repeat (16) @(posedge clk);
    $display("covered %0d items, %0d pixel words, %0d pixel_count settings", items_sent,
             words_checked, settings_used);
    $display("all effects, blanking, stray items, scan turns, strip length limits");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lse_pkg.sv
rtl/core/lse_ctrl.sv
rtl/core/lse_datapath.sv
rtl/core/led_strip_effect_engine.sv
tb/lse_frame_checker.sv
tb/tb_led_strip_effect_engine.sv
